// ===== rtl/swrr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrr_pkg: shared types and constants for the receive reorder core
// Field widths, payload structs, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package swrr_pkg;

	localparam int SEQ_W           = 32;
	localparam int LEN_W           = 9;
	localparam int TAG_W           = 16;
	localparam int WIN_W           = 6;           // window register width
	localparam int SUM_W           = WIN_W + 1;   // slot sum before wrap
	localparam int LEN_CMP_W       = 13;          // holds PAYLOAD_MAX up to 8191
	localparam int WINDOW_MAX_DEF  = 32;
	localparam int PAYLOAD_MAX_DEF = 500;
	localparam int WIN_RST_VAL     = 32;

	localparam logic KIND_DELIVER = 1'b0;
	localparam logic KIND_ACK     = 1'b1;

	typedef struct packed {
		logic [SEQ_W-1:0] seqno;
		logic [LEN_W-1:0] payload_len;
		logic [TAG_W-1:0] packet_tag;
	} swrr_in_t;

	typedef struct packed {
		logic             kind;
		logic [TAG_W-1:0] delivered_tag;
		logic [LEN_W-1:0] delivered_len;
		logic [SEQ_W-1:0] ack_number;
		logic             eof_seen;
		logic             last;
	} swrr_res_t;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [LEN_W-1:0] len;
	} swrr_slot_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_FETCH,
		ST_DRAIN,
		ST_ACK,
		ST_MOD
	} swrr_state_t;

	typedef struct packed {
		logic capture;     // latch incoming request
		logic eval;        // window check and slot store
		logic cfg_load;    // load window register, start remainder unit
		logic drain_step;  // deliver one slot, advance expected
		logic emit_ack;    // present cumulative ack
		logic slot_load;   // take remainder as expected slot
	} swrr_cmd_t;

	typedef struct packed {
		logic hit;         // request is the expected one and stored
		logic can_drain;   // expected slot is filled and window not spent
		logic mod_done;    // remainder unit finished
	} swrr_sts_t;

endpackage

// ===== rtl/swrr_mod.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrr_mod: iterative remainder unit
// Restoring remainder of a 32-bit value by the window size, one dividend
// bit per cycle. Pulses done with the remainder once all SEQ_W bits are in.
// ----------------------------------------------------------------------------
module swrr_mod
	import swrr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SEQ_W-1:0] dividend,
	input  logic [WIN_W-1:0] divisor,
	output logic             done,
	output logic [WIN_W-1:0] rem
);

	localparam int CNT_W = $clog2(SEQ_W + 1);

	logic [SEQ_W-1:0] dvd_q;
	logic [WIN_W-1:0] div_q;
	logic [WIN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [SUM_W-1:0] trial;
	logic [SUM_W-1:0] trial_red;

	assign trial     = {rem_q, dvd_q[SEQ_W-1]};
	assign trial_red = (trial >= SUM_W'(div_q)) ? trial - SUM_W'(div_q) : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(SEQ_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[SEQ_W-2:0], 1'b0};
			rem_q <= trial_red[WIN_W-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// ===== rtl/swrr_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrr_dp: receive reorder datapath
// Window register, expected sequence and slot pointer, slot store with
// valid bits, window check and the registered result port.
// ----------------------------------------------------------------------------
module swrr_dp
	import swrr_pkg::*;
#(
	parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
	parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  swrr_in_t         packet,
	input  logic [WIN_W-1:0] cfg_data,
	input  swrr_cmd_t        cmd,
	output swrr_sts_t        sts,
	output swrr_res_t        result,
	output logic             result_valid
);

	localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int WIN_RST = (WINDOW_MAX < WIN_RST_VAL) ? WINDOW_MAX : WIN_RST_VAL;

	swrr_in_t         pkt_q;
	logic [WIN_W-1:0] win_q;
	logic [SEQ_W-1:0] exp_q;
	logic [IDX_W-1:0] eslot_q;
	logic             eof_q;
	logic [WIN_W-1:0] cnt_q;
	logic [WINDOW_MAX-1:0] valid_q;
	swrr_slot_t       mem_q [WINDOW_MAX];
	swrr_slot_t       rd_q;
	swrr_res_t        result_q;
	logic             result_valid_q;

	logic [WIN_W-1:0] cfg_eff;
	logic [SEQ_W-1:0] base;
	logic [SEQ_W-1:0] offset;
	logic [SEQ_W-1:0] seq_m1;
	logic             in_win;
	logic             len_ok;
	logic             wrapped;
	logic [SUM_W-1:0] sum;
	logic [SUM_W-1:0] sum_red;
	logic [IDX_W-1:0] slot_s;
	logic             store;
	logic [SUM_W-1:0] eslot_inc;
	logic [IDX_W-1:0] eslot_next;
	logic [IDX_W-1:0] rd_addr;
	logic             mod_done;
	logic [WIN_W-1:0] mod_rem;

	// zero means one, above the store depth means the depth
	always_comb begin
		if (cfg_data == '0) begin
			cfg_eff = WIN_W'(1);
		end else if (cfg_data > WIN_W'(WINDOW_MAX)) begin
			cfg_eff = WIN_W'(WINDOW_MAX);
		end else begin
			cfg_eff = cfg_data;
		end
	end

	// window check, all mod 2^32; offset is how far past expected the
	// request lands, in window when below w
	assign base    = exp_q - 1'b1;
	assign offset  = pkt_q.seqno - exp_q;
	assign seq_m1  = pkt_q.seqno - 1'b1;
	assign in_win  = offset < SEQ_W'(win_q);
	assign len_ok  = LEN_CMP_W'(pkt_q.payload_len) <= LEN_CMP_W'(PAYLOAD_MAX);

	// slot = (seq-1) mod w; eslot_q holds (expected-1) mod w, so one
	// wrap suffices unless seq-1 rolled past zero, where seq-1 < w itself
	assign wrapped = seq_m1 < base;
	assign sum     = SUM_W'(eslot_q) + SUM_W'(offset[WIN_W-1:0]);
	assign sum_red = (sum >= SUM_W'(win_q)) ? sum - SUM_W'(win_q) : sum;
	assign slot_s  = wrapped ? seq_m1[IDX_W-1:0] : sum_red[IDX_W-1:0];
	assign store   = cmd.eval && len_ok && in_win;

	// expected wrapping to one restarts the slot count at zero
	assign eslot_inc  = SUM_W'(eslot_q) + SUM_W'(1);
	assign eslot_next = ((exp_q == '0) || (eslot_inc >= SUM_W'(win_q))) ?
		'0 : eslot_inc[IDX_W-1:0];
	assign rd_addr    = cmd.drain_step ? eslot_next : eslot_q;

	assign sts.hit       = len_ok && in_win && (pkt_q.seqno == exp_q);
	assign sts.can_drain = valid_q[eslot_q] && (cnt_q < win_q);
	assign sts.mod_done  = mod_done;

	swrr_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.cfg_load),
		.dividend (base),
		.divisor  (cfg_eff),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pkt_q <= packet;
		end
		if (store) begin
			mem_q[slot_s] <= '{tag: pkt_q.packet_tag, len: pkt_q.payload_len};
		end
		rd_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q          <= WIN_W'(WIN_RST);
			exp_q          <= SEQ_W'(1);
			eslot_q        <= '0;
			eof_q          <= 1'b0;
			cnt_q          <= '0;
			valid_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= cmd.drain_step || cmd.emit_ack;
			if (cmd.cfg_load) begin
				win_q <= cfg_eff;
			end
			if (cmd.slot_load) begin
				eslot_q <= mod_rem[IDX_W-1:0];
			end
			if (cmd.eval) begin
				cnt_q <= '0;
				if (len_ok && (pkt_q.payload_len == '0)) begin
					eof_q <= 1'b1;
				end
			end
			if (store) begin
				valid_q[slot_s] <= 1'b1;
			end
			if (cmd.drain_step) begin
				valid_q[eslot_q] <= 1'b0;
				exp_q            <= exp_q + 1'b1;
				eslot_q          <= eslot_next;
				cnt_q            <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.drain_step) begin
			result_q.kind          <= KIND_DELIVER;
			result_q.delivered_tag <= rd_q.tag;
			result_q.delivered_len <= rd_q.len;
			result_q.ack_number    <= '0;
			result_q.eof_seen      <= eof_q;
			result_q.last          <= 1'b0;
		end else if (cmd.emit_ack) begin
			result_q.kind          <= KIND_ACK;
			result_q.delivered_tag <= '0;
			result_q.delivered_len <= '0;
			result_q.ack_number    <= exp_q;
			result_q.eof_seen      <= eof_q;
			result_q.last          <= 1'b1;
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

endmodule

// ===== rtl/swrr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrr_ctrl: receive reorder controller
// Sequences capture, window check, drain loop, ack and the slot pointer
// recompute after a window size write.
// ----------------------------------------------------------------------------
module swrr_ctrl
	import swrr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      cfg_valid,
	input  swrr_sts_t sts,
	output logic      busy,
	output logic      cfg_ready,
	output swrr_cmd_t cmd
);

	swrr_state_t state_q;
	swrr_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_nxt = ST_EVAL;
				end else if (cfg_valid) begin
					state_nxt = ST_MOD;
				end
			end
			ST_EVAL: begin
				state_nxt = sts.hit ? ST_FETCH : ST_ACK;
			end
			ST_FETCH: begin
				state_nxt = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!sts.can_drain) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_ACK: begin
				state_nxt = ST_IDLE;
			end
			ST_MOD: begin
				if (sts.mod_done) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd       = '0;
		busy      = 1'b1;
		cfg_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy        = 1'b0;
				cfg_ready   = !start;
				cmd.capture = start;
				cmd.cfg_load = cfg_valid && !start;
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
			end
			ST_FETCH: begin
			end
			ST_DRAIN: begin
				cmd.drain_step = sts.can_drain;
				cmd.emit_ack   = !sts.can_drain;
			end
			ST_ACK: begin
				cmd.emit_ack = 1'b1;
			end
			ST_MOD: begin
				cmd.slot_load = sts.mod_done;
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/sliding_window_receive_reorder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_receive_reorder_core: selective-repeat receive window
// Stores out-of-order packets by slot, drains consecutive slots in order
// once the expected packet arrives, and closes every request with a
// cumulative ack of the next expected sequence number.
// ----------------------------------------------------------------------------
//
//  channel   signals                        handshake
//  --------  -----------------------------  -------------------------------
//  packet    start, busy, packet            taken on start && !busy
//  result    result_valid, result           one-cycle strobe, no backpressure
//  config    cfg_valid, cfg_ready, cfg_data written on cfg_valid && cfg_ready
//
//  A request is busy through window check and ack when nothing drains, and
//  through window check, slot fetch and the drain loop when it releases
//  packets; the loop delivers one slot per cycle from the registered slot
//  store, then the ack. Results appear in the cycle after the step that
//  makes them; the ack is last. A window size write keeps the block busy
//  while the remainder unit rebuilds the slot pointer, one sequence bit per
//  cycle. Reset clears valid bits, window to its default, expected to one.
//
module sliding_window_receive_reorder_core
	import swrr_pkg::*;
#(
	parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
	parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF
) (
	input  logic             clk,
	input  logic             arst_n,

	// packet requests
	input  logic             start,
	output logic             busy,
	input  swrr_in_t         packet,

	// deliveries and acks
	output logic             result_valid,
	output swrr_res_t        result,

	// window size register
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [WIN_W-1:0] cfg_data
);

	swrr_cmd_t cmd;
	swrr_sts_t sts;

	// controller: sequencing only, no payload
	swrr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cfg_valid (cfg_valid),
		.sts       (sts),
		.busy      (busy),
		.cfg_ready (cfg_ready),
		.cmd       (cmd)
	);

	// datapath: slot store, sequence state, result register
	swrr_dp #(
		.WINDOW_MAX  (WINDOW_MAX),
		.PAYLOAD_MAX (PAYLOAD_MAX)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.packet       (packet),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.sts          (sts),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule
